/* hw/rtl/stok_pkg.sv */
// Shared types and constants for the script tokenizer.
// Used by every module of the block; depends on nothing.
package stok_pkg;

    // Position counter widths
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Defaults for the top level parameters
    localparam int DEF_MAX_TOKEN   = 1024;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Items one source byte can produce at most
    localparam int MAX_ITEMS = 3;

    // Configuration register indexes
    localparam logic [2:0] CFG_DELIM_LO   = 3'd0;
    localparam logic [2:0] CFG_DELIM_MID  = 3'd1;
    localparam logic [2:0] CFG_DELIM_HIGH = 3'd2;
    localparam logic [2:0] CFG_DELIM_TOP  = 3'd3;
    localparam logic [2:0] CFG_STRIP      = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_DELIM = 2'd1,
        KIND_DQ    = 2'd2,
        KIND_SQ    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [255:0] delim_mask;
        logic         strip_quotes;
    } t_cfg;

    typedef struct packed {
        logic [7:0]             tok_char;
        logic                   char_valid;
        logic                   tok_last;
        t_kind                  tok_kind;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] tok_column;
        logic                   tok_error;
    } t_item;

    // All items caused by one source byte, first item in slot 0
    typedef struct packed {
        logic [1:0]               count;
        t_item [MAX_ITEMS-1:0]    items;
    } t_bundle;

endpackage

/* hw/rtl/stok_front.sv */
// Front scanner: takes one source byte a cycle while not stalled, tracks position
// and scan mode, and forms the bundle of token items the byte causes.
// Depends on stok_pkg.
module stok_front #(
    parameter int MAX_TOKEN = stok_pkg::DEF_MAX_TOKEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_text,
    input  stok_pkg::t_cfg      i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output stok_pkg::t_bundle   o_bundle
);

    localparam int LEN_W = (MAX_TOKEN > 2) ? $clog2(MAX_TOKEN) : 1;
    localparam int LB    = stok_pkg::LINE_BITS;
    localparam int CB    = stok_pkg::COLUMN_BITS;

    typedef enum logic [9:0] {
        M_IDLE    = 10'b00_0000_0001,
        M_SLASH   = 10'b00_0000_0010,
        M_BLOCK   = 10'b00_0000_0100,
        M_BSTAR   = 10'b00_0000_1000,
        M_LINE    = 10'b00_0001_0000,
        M_WORD    = 10'b00_0010_0000,
        M_DQ      = 10'b00_0100_0000,
        M_SQ      = 10'b00_1000_0000,
        M_DQ_SKIP = 10'b01_0000_0000,
        M_SQ_SKIP = 10'b10_0000_0000
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [7:0]       r_hc, n_hc;
    logic             r_hv, n_hv;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LB-1:0]    r_line, n_line, r_sl, n_sl;
    logic [CB-1:0]    r_col, n_col, r_sc, n_sc;
    stok_pkg::t_bundle bundle;
    logic             accept;

    function automatic logic is_space(logic [7:0] c);
        return c == stok_pkg::CH_SPACE || c == stok_pkg::CH_TAB || c == stok_pkg::CH_NL ||
               c == stok_pkg::CH_VT || c == stok_pkg::CH_FF || c == stok_pkg::CH_CR;
    endfunction

    function automatic stok_pkg::t_item mk(logic [7:0] ch, logic cv, logic last,
                                           stok_pkg::t_kind k, logic err,
                                           logic [LB-1:0] ln, logic [CB-1:0] col);
        stok_pkg::t_item it;
        it.tok_char   = ch;
        it.char_valid = cv;
        it.tok_last   = last;
        it.tok_kind   = k;
        it.tok_line   = ln;
        it.tok_column = col;
        it.tok_error  = err;
        return it;
    endfunction

    function automatic stok_pkg::t_bundle add(stok_pkg::t_bundle b, stok_pkg::t_item it);
        stok_pkg::t_bundle r;
        r = b;
        if (b.count != 2'd3) begin
            r.items[b.count] = it;
            r.count          = b.count + 2'd1;
        end
        return r;
    endfunction

    assign accept   = i_valid && !i_full;
    assign o_stall  = i_full;
    assign o_push   = accept && (bundle.count != 2'd0);
    assign o_bundle = bundle;

    // Scan one byte: mode step, then word step, then fresh start, then position, then flush
    always_comb begin
        logic [7:0]      c;
        logic            do_word;
        logic            do_idle;
        logic            c_delim;
        logic            is_dq;
        logic [7:0]      qc;
        stok_pkg::t_kind qk;
        t_mode           qs;

        c       = i_in_byte;
        c_delim = i_cfg.delim_mask[c];
        do_word = 1'b0;
        do_idle = 1'b0;
        is_dq   = (r_mode == M_DQ);
        qc      = is_dq ? stok_pkg::CH_DQ : stok_pkg::CH_SQ;
        qk      = is_dq ? stok_pkg::KIND_DQ : stok_pkg::KIND_SQ;
        qs      = is_dq ? M_DQ_SKIP : M_SQ_SKIP;
        bundle  = '0;
        n_mode  = r_mode;
        n_hc    = r_hc;
        n_hv    = r_hv;
        n_len   = r_len;
        n_sl    = r_sl;
        n_sc    = r_sc;
        n_line  = r_line;
        n_col   = r_col;

        if (c != stok_pkg::CH_NUL) begin
            unique case (r_mode)
                M_SLASH: begin
                    if (c == stok_pkg::CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else if (c == stok_pkg::CH_SLASH) begin
                        n_mode = M_LINE;
                    end else if (i_cfg.delim_mask[stok_pkg::CH_SLASH]) begin
                        bundle  = add(bundle, mk(stok_pkg::CH_SLASH, 1'b1, 1'b1,
                                                 stok_pkg::KIND_DELIM, 1'b0, n_sl, n_sc));
                        do_idle = 1'b1;
                    end else begin
                        n_mode  = M_WORD;
                        n_hc    = stok_pkg::CH_SLASH;
                        n_hv    = 1'b1;
                        n_len   = LEN_W'(1);
                        do_word = 1'b1;
                    end
                end
                M_BLOCK: begin
                    if (c == stok_pkg::CH_STAR) n_mode = M_BSTAR;
                end
                M_BSTAR: begin
                    if (c == stok_pkg::CH_SLASH) n_mode = M_IDLE;
                    else if (c != stok_pkg::CH_STAR) n_mode = M_BLOCK;
                end
                M_LINE: begin
                    if (c == stok_pkg::CH_NL) n_mode = M_IDLE;
                end
                M_WORD: begin
                    do_word = 1'b1;
                end
                M_DQ, M_SQ: begin
                    if (c == qc) begin
                        if (i_cfg.strip_quotes) begin
                            bundle = add(bundle, mk(r_hv ? r_hc : stok_pkg::CH_NUL, r_hv,
                                                    1'b1, qk, 1'b0, n_sl, n_sc));
                        end else begin
                            if (r_hv) begin
                                bundle = add(bundle, mk(r_hc, 1'b1, 1'b0, qk, 1'b0,
                                                        n_sl, n_sc));
                            end
                            bundle = add(bundle, mk(qc, 1'b1, 1'b1, qk, 1'b0, n_sl, n_sc));
                        end
                        n_hv   = 1'b0;
                        n_len  = '0;
                        n_mode = M_IDLE;
                    end else if (r_len >= LEN_W'(MAX_TOKEN - 2)) begin
                        // too long: close with error, skip to the closing quote
                        bundle = add(bundle, mk(r_hv ? r_hc : stok_pkg::CH_NUL, r_hv,
                                                1'b1, qk, 1'b1, n_sl, n_sc));
                        n_hv   = 1'b0;
                        n_len  = '0;
                        n_mode = qs;
                    end else begin
                        if (r_hv) begin
                            bundle = add(bundle, mk(r_hc, 1'b1, 1'b0, qk, 1'b0, n_sl, n_sc));
                        end
                        n_hc  = c;
                        n_hv  = 1'b1;
                        n_len = r_len + LEN_W'(1);
                    end
                end
                M_DQ_SKIP: begin
                    if (c == stok_pkg::CH_DQ) n_mode = M_IDLE;
                end
                M_SQ_SKIP: begin
                    if (c == stok_pkg::CH_SQ) n_mode = M_IDLE;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // Word step: emit the held character, last when the word ends here
            if (do_word) begin
                if (is_space(c) || c == stok_pkg::CH_DQ || c == stok_pkg::CH_SQ || c_delim ||
                    n_len >= LEN_W'(MAX_TOKEN - 1)) begin
                    bundle  = add(bundle, mk(n_hc, 1'b1, 1'b1, stok_pkg::KIND_WORD, 1'b0,
                                             n_sl, n_sc));
                    do_idle = 1'b1;
                end else begin
                    bundle = add(bundle, mk(n_hc, 1'b1, 1'b0, stok_pkg::KIND_WORD, 1'b0,
                                            n_sl, n_sc));
                    n_hc   = c;
                    n_hv   = 1'b1;
                    n_len  = n_len + LEN_W'(1);
                end
            end

            // Fresh start between tokens
            if (do_idle) begin
                n_hv   = 1'b0;
                n_len  = '0;
                n_mode = M_IDLE;
                if (!is_space(c)) begin
                    n_sl = r_line;
                    n_sc = r_col;
                    if (c == stok_pkg::CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (c == stok_pkg::CH_DQ || c == stok_pkg::CH_SQ) begin
                        n_mode = (c == stok_pkg::CH_DQ) ? M_DQ : M_SQ;
                        if (!i_cfg.strip_quotes) begin
                            n_hc = c;
                            n_hv = 1'b1;
                        end
                    end else if (c_delim) begin
                        bundle = add(bundle, mk(c, 1'b1, 1'b1, stok_pkg::KIND_DELIM, 1'b0,
                                                n_sl, n_sc));
                    end else begin
                        n_mode = M_WORD;
                        n_hc   = c;
                        n_hv   = 1'b1;
                        n_len  = LEN_W'(1);
                    end
                end
            end

            // Advance the position, saturating
            if (c == stok_pkg::CH_NL) begin
                if (r_line != '1) n_line = r_line + LB'(1);
                n_col = CB'(1);
            end else if (r_col != '1) begin
                n_col = r_col + CB'(1);
            end
        end

        // End of text or NUL byte: flush what is pending and restart
        if (c == stok_pkg::CH_NUL || i_end_of_text) begin
            unique case (n_mode)
                M_SLASH: begin
                    bundle = add(bundle, mk(stok_pkg::CH_SLASH, 1'b1, 1'b1,
                                            i_cfg.delim_mask[stok_pkg::CH_SLASH] ?
                                            stok_pkg::KIND_DELIM : stok_pkg::KIND_WORD,
                                            1'b0, n_sl, n_sc));
                end
                M_WORD: begin
                    bundle = add(bundle, mk(n_hc, 1'b1, 1'b1, stok_pkg::KIND_WORD, 1'b0,
                                            n_sl, n_sc));
                end
                M_DQ, M_SQ: begin
                    bundle = add(bundle, mk(n_hv ? n_hc : stok_pkg::CH_NUL, n_hv, 1'b1,
                                            (n_mode == M_DQ) ? stok_pkg::KIND_DQ :
                                            stok_pkg::KIND_SQ, 1'b1, n_sl, n_sc));
                end
                M_BLOCK, M_BSTAR: begin
                    bundle = add(bundle, mk(stok_pkg::CH_NUL, 1'b0, 1'b1,
                                            stok_pkg::KIND_WORD, 1'b1, n_sl, n_sc));
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
            n_hc   = '0;
            n_hv   = 1'b0;
            n_len  = '0;
            n_line = LB'(1);
            n_col  = CB'(1);
            n_sl   = LB'(1);
            n_sc   = CB'(1);
        end
    end

    // Hold scan state; advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hc   <= '0;
            r_hv   <= 1'b0;
            r_len  <= '0;
            r_line <= LB'(1);
            r_col  <= CB'(1);
            r_sl   <= LB'(1);
            r_sc   <= CB'(1);
        end else if (accept) begin
            r_mode <= n_mode;
            r_hc   <= n_hc;
            r_hv   <= n_hv;
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_sl   <= n_sl;
            r_sc   <= n_sc;
        end
    end

endmodule

/* hw/rtl/stok_queue.sv */
// Short bundle queue between the front scanner and the output stage.
// Depends on stok_pkg.
module stok_queue #(
    parameter int DEPTH = stok_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stok_pkg::t_bundle i_bundle,
    input  logic              i_pop,
    output stok_pkg::t_bundle o_head,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stok_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

    // Advance pointers with explicit wrap
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) n_cnt = r_cnt + CNT_W'(1);
        else if (i_pop && !i_push) n_cnt = r_cnt - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed bundle
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_bundle;
    end

endmodule

/* hw/rtl/stok_back.sv */
// Output stage: walks the items of the head bundle into a registered
// output beat. Depends on stok_pkg.
module stok_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stok_pkg::t_bundle i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output stok_pkg::t_item   o_item
);

    logic [1:0]      r_sel, n_sel;
    logic            r_valid, n_valid;
    stok_pkg::t_item r_item;
    logic            load;
    logic            at_end;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign at_end  = (r_sel == i_head.count - 2'd1);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Step to the next item, or wrap when the bundle is done
    always_comb begin
        n_sel   = r_sel;
        n_valid = r_valid && i_stall;
        if (load) begin
            n_valid = 1'b1;
            n_sel   = at_end ? 2'd0 : r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_sel   <= n_sel;
            r_valid <= n_valid;
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (load) r_item <= i_head.items[r_sel];
    end

endmodule

/* hw/rtl/script_tokenizer.sv */
// Script tokenizer top level: config registers, front scanner, bundle queue
// and output stage. Depends on stok_pkg, stok_front, stok_queue, stok_back.
// An accepted byte's bundle is registered in the queue, then its first item in the output beat.
// Throughput: one byte per cycle while the queue has room; the output stage
// moves one item per cycle while not stalled, so bytes causing 2 or 3 items drain one by one.
// Reset (synchronous, active low) clears scan state, position to line 1
// column 1, the queue, the output valid flag and all config registers.
module script_tokenizer #(
    parameter int MAX_TOKEN   = stok_pkg::DEF_MAX_TOKEN,
    parameter int QUEUE_DEPTH = stok_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_end_of_text,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [7:0]                          o_tok_char,
    output logic                                o_char_valid,
    output logic                                o_tok_last,
    output logic [1:0]                          o_tok_kind,
    output logic [stok_pkg::LINE_BITS-1:0]      o_tok_line,
    output logic [stok_pkg::COLUMN_BITS-1:0]    o_tok_column,
    output logic                                o_tok_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    stok_pkg::t_cfg    r_cfg;
    stok_pkg::t_bundle fr_bundle, q_head;
    stok_pkg::t_item   out_item;
    logic              q_push, q_pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    // Write config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                stok_pkg::CFG_DELIM_LO:   r_cfg.delim_mask[63:0]    <= i_cfg_data;
                stok_pkg::CFG_DELIM_MID:  r_cfg.delim_mask[127:64]  <= i_cfg_data;
                stok_pkg::CFG_DELIM_HIGH: r_cfg.delim_mask[191:128] <= i_cfg_data;
                stok_pkg::CFG_DELIM_TOP:  r_cfg.delim_mask[255:192] <= i_cfg_data;
                stok_pkg::CFG_STRIP:      r_cfg.strip_quotes        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    stok_front #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_cfg         (r_cfg),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_bundle      (fr_bundle)
    );

    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (fr_bundle),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    stok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (out_item)
    );

    assign o_tok_char   = out_item.tok_char;
    assign o_char_valid = out_item.char_valid;
    assign o_tok_last   = out_item.tok_last;
    assign o_tok_kind   = out_item.tok_kind;
    assign o_tok_line   = out_item.tok_line;
    assign o_tok_column = out_item.tok_column;
    assign o_tok_error  = out_item.tok_error;

    // A bundle is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("bundle pushed into full queue");

    // The output stage never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // Reset leaves no beat on the output and nothing queued
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && q_empty))
        else $error("state left after reset");

endmodule

/* verif/tb_script_tokenizer.sv */
// Self-checking bench for script_tokenizer: drives source text, predicts token items.
// Depends on stok_pkg and the script_tokenizer RTL only.
module tb_script_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import stok_pkg::*;

    localparam int TOKEN_CAP = DEF_MAX_TOKEN;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [COLUMN_BITS-1:0] COL_TOP = '1;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_SLASH, SCAN_BLOCK, SCAN_BSTAR, SCAN_LINE,
        SCAN_WORD, SCAN_DQ, SCAN_SQ, SCAN_DQ_SKIP, SCAN_SQ_SKIP
    } t_scan;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_src_beat;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [7:0]             i_in_byte = 8'h00;
    logic                   i_end_of_text = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [7:0]             o_tok_char;
    logic                   o_char_valid;
    logic                   o_tok_last;
    logic [1:0]             o_tok_kind;
    logic [LINE_BITS-1:0]   o_tok_line;
    logic [COLUMN_BITS-1:0] o_tok_column;
    logic                   o_tok_error;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_index = CFG_DELIM_LO;
    logic [63:0]            i_cfg_data = 64'd0;

    // Source text waiting to go out, and token items still owed by the block
    t_src_beat   src_bytes[$];
    t_item       tok_items_due[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned bad_items = 0;
    logic [255:0] phase_mask = '0;

    // Scanner shadow state
    t_scan                  scan;
    logic [7:0]             held_ch;
    logic                   held_ok;
    int unsigned            tok_len;
    logic [LINE_BITS-1:0]   cur_line, first_line;
    logic [COLUMN_BITS-1:0] cur_col, first_col;
    logic [255:0]           delim_set;
    logic                   strip_q;

    script_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tok_char    (o_tok_char),
        .o_char_valid  (o_char_valid),
        .o_tok_last    (o_tok_last),
        .o_tok_kind    (o_tok_kind),
        .o_tok_line    (o_tok_line),
        .o_tok_column  (o_tok_column),
        .o_tok_error   (o_tok_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_blank(logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    endfunction

    function automatic void add_item(logic [7:0] ch, logic ok, logic last, t_kind kind,
                                     logic err);
        t_item it;
        it.tok_char   = ch;
        it.char_valid = ok;
        it.tok_last   = last;
        it.tok_kind   = kind;
        it.tok_line   = first_line;
        it.tok_column = first_col;
        it.tok_error  = err;
        tok_items_due.push_back(it);
    endfunction

    // Close a quoted token on the held character, or on a bare closing item
    function automatic void close_held(t_kind kind, logic err);
        if (held_ok) begin
            add_item(held_ch, 1'b1, 1'b1, kind, err);
        end else begin
            add_item(CH_NUL, 1'b0, 1'b1, kind, err);
        end
    endfunction

    function automatic void restart();
        scan       = SCAN_IDLE;
        held_ch    = 8'h00;
        held_ok    = 1'b0;
        tok_len    = 0;
        cur_line   = 1;
        cur_col    = 1;
        first_line = 1;
        first_col  = 1;
    endfunction

    // Begin scanning afresh from between tokens
    function automatic void start_token(logic [7:0] c);
        held_ok = 1'b0;
        tok_len = 0;
        scan    = SCAN_IDLE;
        if (!is_blank(c)) begin
            first_line = cur_line;
            first_col  = cur_col;
            if (c == CH_SLASH) begin
                scan = SCAN_SLASH;
            end else if (c == CH_DQ || c == CH_SQ) begin
                scan = (c == CH_DQ) ? SCAN_DQ : SCAN_SQ;
                if (!strip_q) begin
                    held_ch = c;
                    held_ok = 1'b1;
                end
            end else if (delim_set[c]) begin
                add_item(c, 1'b1, 1'b1, KIND_DELIM, 1'b0);
            end else begin
                scan    = SCAN_WORD;
                held_ch = c;
                held_ok = 1'b1;
                tok_len = 1;
            end
        end
    endfunction

    function automatic void word_step(logic [7:0] c);
        if (is_blank(c) || c == CH_DQ || c == CH_SQ || delim_set[c] ||
            tok_len >= TOKEN_CAP - 1) begin
            add_item(held_ch, 1'b1, 1'b1, KIND_WORD, 1'b0);
            start_token(c);
        end else begin
            add_item(held_ch, 1'b1, 1'b0, KIND_WORD, 1'b0);
            held_ch = c;
            held_ok = 1'b1;
            tok_len++;
        end
    endfunction

    function automatic void quote_step(logic [7:0] c, logic [7:0] q, t_kind kind,
                                       t_scan skip);
        if (c == q) begin
            if (strip_q) begin
                close_held(kind, 1'b0);
            end else begin
                if (held_ok) add_item(held_ch, 1'b1, 1'b0, kind, 1'b0);
                add_item(q, 1'b1, 1'b1, kind, 1'b0);
            end
            held_ok = 1'b0;
            tok_len = 0;
            scan    = SCAN_IDLE;
        end else if (tok_len >= TOKEN_CAP - 2) begin
            // too long: close with an error and drop the rest of the quote
            close_held(kind, 1'b1);
            held_ok = 1'b0;
            tok_len = 0;
            scan    = skip;
        end else begin
            if (held_ok) add_item(held_ch, 1'b1, 1'b0, kind, 1'b0);
            held_ch = c;
            held_ok = 1'b1;
            tok_len++;
        end
    endfunction

    // Work out every item that one accepted source byte causes
    function automatic void tokenize_byte(logic [7:0] c, logic eot);
        if (c != CH_NUL) begin
            case (scan)
                SCAN_SLASH: begin
                    if (c == CH_STAR) begin
                        scan = SCAN_BLOCK;
                    end else if (c == CH_SLASH) begin
                        scan = SCAN_LINE;
                    end else if (delim_set[CH_SLASH]) begin
                        add_item(CH_SLASH, 1'b1, 1'b1, KIND_DELIM, 1'b0);
                        start_token(c);
                    end else begin
                        scan    = SCAN_WORD;
                        held_ch = CH_SLASH;
                        held_ok = 1'b1;
                        tok_len = 1;
                        word_step(c);
                    end
                end
                SCAN_BLOCK: if (c == CH_STAR) scan = SCAN_BSTAR;
                SCAN_BSTAR: begin
                    if (c == CH_SLASH) scan = SCAN_IDLE;
                    else if (c != CH_STAR) scan = SCAN_BLOCK;
                end
                SCAN_LINE:    if (c == CH_NL) scan = SCAN_IDLE;
                SCAN_WORD:    word_step(c);
                SCAN_DQ:      quote_step(c, CH_DQ, KIND_DQ, SCAN_DQ_SKIP);
                SCAN_SQ:      quote_step(c, CH_SQ, KIND_SQ, SCAN_SQ_SKIP);
                SCAN_DQ_SKIP: if (c == CH_DQ) scan = SCAN_IDLE;
                SCAN_SQ_SKIP: if (c == CH_SQ) scan = SCAN_IDLE;
                default:      start_token(c);
            endcase
            // advance the position, saturating
            if (c == CH_NL) begin
                if (cur_line != LINE_TOP) cur_line++;
                cur_col = 1;
            end else if (cur_col != COL_TOP) begin
                cur_col++;
            end
        end
        if (c == CH_NUL || eot) begin
            // flush whatever is open, then start the next text from scratch
            case (scan)
                SCAN_SLASH: add_item(CH_SLASH, 1'b1, 1'b1,
                                     delim_set[CH_SLASH] ? KIND_DELIM : KIND_WORD, 1'b0);
                SCAN_WORD:  add_item(held_ch, 1'b1, 1'b1, KIND_WORD, 1'b0);
                SCAN_DQ:    close_held(KIND_DQ, 1'b1);
                SCAN_SQ:    close_held(KIND_SQ, 1'b1);
                SCAN_BLOCK, SCAN_BSTAR: add_item(CH_NUL, 1'b0, 1'b1, KIND_WORD, 1'b1);
                default: ;
            endcase
            restart();
        end
    endfunction

    function automatic string item_text(t_item it);
        return $sformatf("char %02h cv %0b last %0b kind %0d line %0d col %0d err %0b",
                         it.tok_char, it.char_valid, it.tok_last, it.tok_kind,
                         it.tok_line, it.tok_column, it.tok_error);
    endfunction

    // ---------------------------------------------------------------- monitor

    // Track config writes and accepted bytes, then check each output beat
    always @(posedge i_clk) begin : watch_block
        t_item got;
        t_item want;
        if (!i_rst_n) begin
            restart();
            delim_set = '0;
            strip_q   = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELIM_LO:   delim_set[63:0]    = i_cfg_data;
                    CFG_DELIM_MID:  delim_set[127:64]  = i_cfg_data;
                    CFG_DELIM_HIGH: delim_set[191:128] = i_cfg_data;
                    CFG_DELIM_TOP:  delim_set[255:192] = i_cfg_data;
                    CFG_STRIP:      strip_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                tokenize_byte(i_in_byte, i_end_of_text);
                bytes_taken++;
            end
            if (o_valid && !i_stall) begin
                got = {o_tok_char, o_char_valid, o_tok_last, o_tok_kind,
                       o_tok_line, o_tok_column, o_tok_error};
                if (tok_items_due.size() == 0) begin
                    bad_items++;
                    if (bad_items <= 10) $display("unexpected item: %s", item_text(got));
                end else begin
                    want = tok_items_due.pop_front();
                    if (got !== want) begin
                        bad_items++;
                        if (bad_items <= 10) begin
                            $display("item mismatch: expected %s", item_text(want));
                            $display("               actual   %s", item_text(got));
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- driver

    int        burst_left = 0;
    int        gap_left = 0;
    t_src_beat next_beat;

    // Send source bytes in bursts; hold a stalled beat unchanged
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (src_bytes.size() != 0) begin
                next_beat = src_bytes.pop_front();
                i_valid       <= 1'b1;
                i_in_byte     <= next_beat.ch;
                i_end_of_text <= next_beat.eot;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                               : $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: switch between stall patterns every so often
    logic [1:0] stall_style = 2'd0;
    int         stall_span = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_span <= 0;
        end else begin
            if (stall_span == 0) begin
                stall_style <= 2'($urandom_range(0, 3));
                stall_span  <= $urandom_range(20, 120);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_style)
                2'd0:    i_stall <= 1'b0;
                2'd1:    i_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // Abort when nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("script_tokenizer test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- text generation

    task automatic push_byte(logic [7:0] c);
        t_src_beat b;
        b.ch  = c;
        b.eot = 1'b0;
        src_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    // Mark the last queued byte as the end of the text
    task automatic end_text();
        t_src_beat b;
        b = src_bytes.pop_back();
        b.eot = 1'b1;
        src_bytes.push_back(b);
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Fill with n copies of c, or with random letters when c is NUL
    task automatic push_fill(int n, logic [7:0] c);
        for (int i = 0; i < n; i++) push_byte((c == CH_NUL) ? letter() : c);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 7))
            0:       return CH_TAB;
            1:       return CH_NL;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) != 0 || is_blank(c) || c == CH_DQ || c == CH_SQ) c = letter();
        return c;
    endfunction

    function automatic logic [7:0] delim_char();
        logic [7:0] c;
        for (int t = 0; t < 32; t++) begin
            c = 8'($urandom_range(1, 255));
            if (phase_mask[c] && !is_blank(c) && c != CH_DQ && c != CH_SQ) return c;
        end
        return letter();
    endfunction

    function automatic logic [7:0] inner_char(logic [7:0] q);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return (c == q) ? letter() : c;
    endfunction

    function automatic logic [7:0] comment_char();
        case ($urandom_range(0, 5))
            0, 1:    return CH_STAR;
            2:       return CH_SLASH;
            3:       return CH_NL;
            default: return letter();
        endcase
    endfunction

    // One text: a run of tokens, comments and noise, closed in one of several ways
    task automatic gen_text();
        int         n_tok;
        int         len;
        logic [7:0] q;
        n_tok = $urandom_range(1, 8);
        for (int k = 0; k < n_tok; k++) begin
            case ($urandom_range(0, 11))
                0, 1, 2: begin
                    len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
                    for (int j = 0; j < len; j++) push_byte(word_char());
                end
                3, 4: push_byte(delim_char());
                5: begin
                    q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                    push_byte(q);
                    len = $urandom_range(0, 6);
                    for (int j = 0; j < len; j++) push_byte(inner_char(q));
                    push_byte(q);
                end
                6: begin
                    push_byte(CH_SLASH);
                    push_byte(CH_STAR);
                    len = $urandom_range(0, 5);
                    for (int j = 0; j < len; j++) push_byte(comment_char());
                    push_byte(CH_STAR);
                    push_byte(CH_SLASH);
                end
                7: begin
                    push_byte(CH_SLASH);
                    push_byte(CH_SLASH);
                    len = $urandom_range(0, 5);
                    for (int j = 0; j < len; j++) push_byte(comment_char());
                    push_byte(CH_NL);
                end
                8:  push_byte(CH_SLASH);
                9:  push_byte(8'($urandom_range(0, 255)));
                default: begin
                    len = $urandom_range(1, 3);
                    for (int j = 0; j < len; j++) push_byte(blank_char());
                end
            endcase
            if ($urandom_range(0, 2) != 0) push_byte(blank_char());
        end
        case ($urandom_range(0, 9))
            6, 7: begin
                push_byte(CH_NUL);
                if ($urandom_range(0, 1) != 0) end_text();
            end
            8: begin
                // quote left open at the end
                q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                push_byte(q);
                len = $urandom_range(0, 4);
                for (int j = 0; j < len; j++) push_byte(inner_char(q));
                end_text();
            end
            9: begin
                // block comment left open at the end
                push_byte(CH_SLASH);
                push_byte(CH_STAR);
                len = $urandom_range(0, 4);
                for (int j = 0; j < len; j++) push_byte(comment_char());
                end_text();
            end
            default: end_text();
        endcase
    endtask

    task automatic gen_random(int unsigned n);
        int unsigned mark;
        mark = bytes_queued;
        while (bytes_queued - mark < n) gen_text();
    endtask

    // ---------------------------------------------------------------- sequencing

    // Wait until every byte is taken and every item has come out
    task automatic drain();
        while (bytes_taken != bytes_queued || tok_items_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(logic [255:0] mask, logic strip);
        drain();
        phase_mask = mask;
        write_reg(CFG_DELIM_LO, mask[63:0]);
        write_reg(CFG_DELIM_MID, mask[127:64]);
        write_reg(CFG_DELIM_HIGH, mask[191:128]);
        write_reg(CFG_DELIM_TOP, mask[255:192]);
        write_reg(CFG_STRIP, {63'd0, strip});
    endtask

    initial begin
        logic [255:0] mask;
        string        punct;
        punct = ";,()={}/";
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Punctuation delimiters, slash and 0xFF among them, quotes kept
        mask = '0;
        for (int i = 0; i < punct.len(); i++) mask[punct[i]] = 1'b1;
        mask[8'hFF] = 1'b1;
        set_phase(mask, 1'b0);
        push_text("ab;\"q\" 'r' / x//c\n/**/z");
        push_byte(8'hFF);
        end_text();
        push_text("\"ab");
        end_text();
        push_text("/*");
        end_text();
        push_byte(CH_SQ);
        push_byte(CH_NUL);
        gen_random(45);

        // Every code a delimiter, quotes stripped
        set_phase('1, 1'b1);
        push_text("\"\"'ab' /x");
        end_text();
        push_byte(CH_SQ);
        end_text();
        gen_random(45);

        // No delimiters, quotes stripped: plain words and quotes, lone slashes
        set_phase('0, 1'b1);
        push_fill(12, CH_NUL);
        push_byte(CH_SPACE);
        push_byte(CH_DQ);
        push_fill(5, CH_NUL);
        push_byte(CH_DQ);
        end_text();
        push_text("/a /");
        end_text();
        gen_random(45);

        // Random delimiters, quotes kept
        mask = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        set_phase(mask, 1'b0);
        push_byte(CH_DQ);
        push_fill(6, CH_NUL);
        push_byte(CH_DQ);
        end_text();
        push_text("q r");
        end_text();
        gen_random(45);

        drain();
        if (bad_items == 0 && tok_items_due.size() == 0) begin
            $display("script_tokenizer test passed");
        end else begin
            $display("script_tokenizer test failed");
        end
        $finish;
    end

endmodule
